[rtl/core/bls_pkg.sv]
// Shared types and constants for the bounded LIFO stack.
// No dependencies; imported by every module in rtl/core.
`default_nettype none
package bls_pkg;

   localparam int DEPTH   = 256;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 9;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W   = $clog2(DEPTH + 1);

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [OCC_W-1:0]         occ_type;
   typedef logic [COUNT_W-1:0]       count_type;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_TOP     = 2'd2,
      OP_REVERSE = 2'd3
   } func_type;

   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      addr_type addr;
      word_type wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic      ok;
      logic      rd_sel;
      count_type count;
   } rsp_info_type;

endpackage
`default_nettype wire

[rtl/core/bls_ram.sv]
// Single-port word store with registered read data.
// Depends on bls_pkg for the depth and command type.
`default_nettype none
module bls_ram
   import bls_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_cmd_type cmd,
   output word_type         rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/bls_ctrl.sv]
// Stack pointer control: occupancy, circular base and direction, address mapping.
// Depends on bls_pkg; drives the command port of bls_ram.
`default_nettype none
module bls_ctrl
   import bls_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     accept,
   input  wire logic [1:0] func,
   input  wire word_type data,
   output mem_cmd_type   mem_cmd,
   output rsp_info_type  info
);

   localparam occ_type            FULL    = OCC_W'(DEPTH);
   localparam logic [ADDR_W:0]    DEPTH_X = (ADDR_W+1)'(DEPTH);

   occ_type  occ_ff, occ_in;
   addr_type base_ff, base_in;
   logic     dir_ff, dir_in;

   func_type        op;
   occ_type         idx;
   addr_type        idx_a;
   logic [ADDR_W:0] fwd;
   logic [ADDR_W:0] bwd;
   addr_type        phys;
   logic            empty;
   logic            full;

   assign op    = func_type'(func);
   assign empty = (occ_ff == '0);
   assign full  = (occ_ff == FULL);
   assign idx   = (op == OP_PUSH) ? occ_ff : occ_ff - OCC_W'(1);
   assign idx_a = ADDR_W'(idx);
   assign fwd   = {1'b0, base_ff} + {1'b0, idx_a};
   assign bwd   = {1'b0, base_ff} - {1'b0, idx_a};

   always_comb begin
      if (!dir_ff) begin
         phys = (fwd >= DEPTH_X) ? ADDR_W'(fwd - DEPTH_X) : ADDR_W'(fwd);
      end else begin
         phys = bwd[ADDR_W] ? ADDR_W'(bwd + DEPTH_X) : ADDR_W'(bwd);
      end
   end

   always_comb begin
      occ_in          = occ_ff;
      base_in         = base_ff;
      dir_in          = dir_ff;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.rd_en   = 1'b0;
      mem_cmd.addr    = phys;
      mem_cmd.wr_data = data;
      info.ok         = 1'b0;
      info.rd_sel     = 1'b0;
      unique case (op)
         OP_PUSH: begin
            if (!full) begin
               info.ok       = 1'b1;
               mem_cmd.wr_en = accept;
               occ_in        = occ_ff + OCC_W'(1);
            end
         end
         OP_POP: begin
            if (!empty) begin
               info.ok       = 1'b1;
               info.rd_sel   = 1'b1;
               mem_cmd.rd_en = accept;
               occ_in        = occ_ff - OCC_W'(1);
            end
         end
         OP_TOP: begin
            if (!empty) begin
               info.ok       = 1'b1;
               info.rd_sel   = 1'b1;
               mem_cmd.rd_en = accept;
            end
         end
         OP_REVERSE: begin
            info.ok = 1'b1;
            if (!empty) begin
               base_in = phys;
               dir_in  = ~dir_ff;
            end
         end
      endcase
      info.count = COUNT_W'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         base_ff <= '0;
         dir_ff  <= 1'b0;
      end else if (accept) begin
         occ_ff  <= occ_in;
         base_ff <= base_in;
         dir_ff  <= dir_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL) else $error("occupancy above depth");

   a_base_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, base_ff} < DEPTH_X) else $error("base pointer out of range");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en)) else $error("read and write in one beat");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_PUSH && !full) |=> occ_ff == $past(occ_ff) + OCC_W'(1))
      else $error("push did not advance occupancy");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(occ_ff) && $stable(base_ff) && $stable(dir_ff))
      else $error("pointer state moved without a beat");
`endif

endmodule
`default_nettype wire

[rtl/core/bounded_lifo_stack.sv]
// Bounded LIFO stack of signed words: one result beat per request beat.
// The result is valid in the cycle after the request beat is accepted.
// Throughput: one request per cycle for every operation while rsp_ready is high;
// reverse remaps the circular base and direction instead of moving words.
// Reset clears occupancy and the response valid flag; the word store is not cleared.
// Depends on bls_pkg, bls_ctrl and bls_ram.
`default_nettype none
module bounded_lifo_stack
   import bls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire word_type    req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_ok,
   output word_type         rsp_value,
   output count_type        rsp_count
);

   logic         accept;
   mem_cmd_type  mem_cmd;
   rsp_info_type info;
   word_type     rd_data;

   logic         rsp_valid_ff;
   rsp_info_type info_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   bls_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req_func),
      .data    (req_data),
      .mem_cmd (mem_cmd),
      .info    (info)
   );

   bls_ram u_ram (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = info_ff.ok;
   assign rsp_value = info_ff.rd_sel ? rd_data : '0;
   assign rsp_count = info_ff.count;

endmodule
`default_nettype wire
